[rtl/pfd_pkg.sv]
package pfd_pkg;

  localparam logic [7:0] CrcPoly   = 8'h8C;
  localparam logic [7:0] HdrFirst  = 8'h55;
  localparam logic [7:0] HdrSecond = 8'hAA;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  localparam int unsigned IndexW   = 9;
  localparam int unsigned PayloadN = 7;
  localparam int unsigned OutW     = 64;

  localparam logic [IndexW-1:0] PosHdr0    = IndexW'(0);
  localparam logic [IndexW-1:0] PosHdr1    = IndexW'(1);
  localparam logic [IndexW-1:0] PosLen     = IndexW'(2);
  localparam logic [IndexW-1:0] PosPayload = IndexW'(3);

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_HDR_ERR = 2'd1,
    STAT_CRC_ERR = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]         ctrl_flag;
    logic signed [15:0] yaw;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
    status_e            status;
  } pose_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/pose_frame_deframer_crc8.sv]
// Channel   Dir  Signals                      Payload
// s_axis    in   tvalid/tready/tdata[7:0]     rx_byte
// m_axis    out  tvalid/tready/tdata[63:0]    status, pos_x, pos_y, yaw, ctrl_flag
//
// One byte is taken per cycle unless a frame-ending byte is held; a frame result is offered once
// its line feed has passed the input register and been loaded into the output register.
// The byte sits in an input register while the frame state and CRC are updated.
// Only a byte that ends a frame waits on a full output register; other bytes never stall.
// Reset clears the frame state, the header flag reads as good, and both registers empty.
module pose_frame_deframer_crc8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [pfd_pkg::OutW-1:0] m_axis_tdata_o // [1:0] status, [17:2] pos_x,
                                                  // [33:18] pos_y, [49:34] yaw,
                                                  // [57:50] ctrl_flag
);
  import pfd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       end_frame;
  logic       room;
  logic       step;
  pose_t      frame_res;
  pose_t      out_res;

  assign step            = in_valid_q && (!end_frame || room);
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  pfd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte_q),
    .end_frame_o (end_frame),
    .result_o    (frame_res)
  );

  pfd_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && end_frame),
    .result_i (frame_res),
    .room_o   (room),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = OutW'(out_res);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_res.status != STAT_OK |->
      out_res.pos_x == '0 && out_res.pos_y == '0 && out_res.yaw == '0 &&
      out_res.ctrl_flag == '0)
    else $error("error result carries nonzero payload");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_res.status == STAT_OK || out_res.status == STAT_HDR_ERR ||
      out_res.status == STAT_CRC_ERR)
    else $error("result status out of range");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_valid_q) && $past(end_frame))
    else $error("result appeared without a terminating byte");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("empty input register refused a transaction");

endmodule

[rtl/pfd_frame.sv]
module pfd_frame (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    rx_byte_i,
  output logic          end_frame_o,
  output pfd_pkg::pose_t result_o
);
  import pfd_pkg::*;

  logic [IndexW-1:0] byte_index_q, byte_index_d;
  logic              header_ok_q, header_ok_d;
  logic [7:0]        frame_length_q, frame_length_d;
  logic [7:0]        running_crc_q, running_crc_d;
  logic [7:0]        received_crc_q, received_crc_d;
  logic              crc_seen_q, crc_seen_d;
  logic [7:0]        payload_q [PayloadN];
  logic [7:0]        payload_d [PayloadN];
  logic              last_was_cr_q, last_was_cr_d;

  logic [7:0]        len;
  logic [IndexW:0]   pos_ext;
  logic [IndexW:0]   crc_last;
  logic [7:0]        crc_next;
  pose_t             res;

  assign len      = (byte_index_q == PosLen) ? rx_byte_i : frame_length_q;
  assign pos_ext  = {1'b0, byte_index_q};
  assign crc_last = (IndexW + 1)'(len) + (IndexW + 1)'(2);
  assign crc_next = crc8_update(running_crc_q, rx_byte_i);
  assign end_frame_o = last_was_cr_q && (rx_byte_i == CharLf);

  always_comb begin
    header_ok_d    = header_ok_q;
    frame_length_d = len;
    running_crc_d  = running_crc_q;
    received_crc_d = received_crc_q;
    crc_seen_d     = crc_seen_q;
    if (byte_index_q == PosHdr0 && rx_byte_i != HdrFirst) begin
      header_ok_d = 1'b0;
    end
    if (byte_index_q == PosHdr1 && rx_byte_i != HdrSecond) begin
      header_ok_d = 1'b0;
    end
    if (pos_ext <= crc_last) begin
      running_crc_d = crc_next;
    end else if (pos_ext == crc_last + (IndexW + 1)'(1)) begin
      received_crc_d = rx_byte_i;
      crc_seen_d     = 1'b1;
    end
    for (int i = 0; i < PayloadN; i++) begin
      payload_d[i] = (byte_index_q == PosPayload + IndexW'(i)) ? rx_byte_i : payload_q[i];
    end
    last_was_cr_d = (rx_byte_i == CharCr);
    byte_index_d  = (byte_index_q == '1) ? byte_index_q : byte_index_q + IndexW'(1);
  end

  always_comb begin
    res = '0;
    if (!header_ok_d) begin
      res.status = STAT_HDR_ERR;
    end else if (!crc_seen_d || running_crc_d != received_crc_d) begin
      res.status = STAT_CRC_ERR;
    end else begin
      res.status    = STAT_OK;
      res.pos_x     = {payload_d[1], payload_d[0]};
      res.pos_y     = {payload_d[3], payload_d[2]};
      res.yaw       = {payload_d[5], payload_d[4]};
      res.ctrl_flag = payload_d[6];
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= '0;
      header_ok_q    <= 1'b1;
      frame_length_q <= '0;
      running_crc_q  <= '0;
      received_crc_q <= '0;
      crc_seen_q     <= 1'b0;
      last_was_cr_q  <= 1'b0;
      for (int i = 0; i < PayloadN; i++) begin
        payload_q[i] <= '0;
      end
    end else if (step_i) begin
      if (end_frame_o) begin
        byte_index_q   <= '0;
        header_ok_q    <= 1'b1;
        frame_length_q <= '0;
        running_crc_q  <= '0;
        received_crc_q <= '0;
        crc_seen_q     <= 1'b0;
        last_was_cr_q  <= 1'b0;
        for (int i = 0; i < PayloadN; i++) begin
          payload_q[i] <= '0;
        end
      end else begin
        byte_index_q   <= byte_index_d;
        header_ok_q    <= header_ok_d;
        frame_length_q <= frame_length_d;
        running_crc_q  <= running_crc_d;
        received_crc_q <= received_crc_d;
        crc_seen_q     <= crc_seen_d;
        last_was_cr_q  <= last_was_cr_d;
        for (int i = 0; i < PayloadN; i++) begin
          payload_q[i] <= payload_d[i];
        end
      end
    end
  end

endmodule

[rtl/pfd_out_reg.sv]
module pfd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  pfd_pkg::pose_t result_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output pfd_pkg::pose_t result_o
);
  import pfd_pkg::*;

  logic  valid_q;
  pose_t result_q;

  assign room_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

[test/tb_pose_frame_deframer_crc8.sv]
module tb_pose_frame_deframer_crc8;
  import pfd_pkg::*;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomBytes   = 860;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [OutW-1:0] m_axis_tdata_o;

  pose_frame_deframer_crc8 DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Frame tracking state, mirrored from the block's behavior.
  logic [IndexW-1:0] fr_pos;
  logic              fr_hdr_ok;
  logic [7:0]        fr_len;
  logic [7:0]        fr_crc;
  logic [7:0]        fr_crc_rx;
  logic              fr_crc_got;
  logic [7:0]        fr_body [PayloadN];
  logic              fr_cr;

  pose_t       pending_poses[$];
  logic [7:0]  tx_buf[$];
  int unsigned errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_ok = 0;
  int unsigned n_hdr = 0;
  int unsigned n_crc = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned ready_cyc = 0;
  int unsigned ready_mode = 0;
  bit          hold_req = 1'b0;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) r = r ^ CrcPoly;
    end
    return r;
  endfunction

  function automatic void frame_clear();
    fr_pos = '0;
    fr_hdr_ok = 1'b1;
    fr_len = 8'h00;
    fr_crc = 8'h00;
    fr_crc_rx = 8'h00;
    fr_crc_got = 1'b0;
    foreach (fr_body[i]) fr_body[i] = 8'h00;
    fr_cr = 1'b0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    int    pos;
    int    lim;
    logic  eof;
    pose_t res;
    pos = int'(fr_pos);
    lim = int'(fr_len);
    if (pos == 0 && b != HdrFirst) fr_hdr_ok = 1'b0;
    if (pos == 1 && b != HdrSecond) fr_hdr_ok = 1'b0;
    if (pos == 2) begin
      fr_len = b;
      lim = int'(b);
    end
    if (pos <= lim + 2) begin
      fr_crc = crc8_next(fr_crc, b);
    end else if (pos == lim + 3) begin
      fr_crc_rx = b;
      fr_crc_got = 1'b1;
    end
    if (pos >= 3 && pos < 3 + int'(PayloadN)) fr_body[pos-3] = b;
    eof = fr_cr && (b == CharLf);
    fr_cr = (b == CharCr);
    if (fr_pos != {IndexW{1'b1}}) fr_pos = fr_pos + 1'b1;
    if (eof) begin
      res = '0;
      if (!fr_hdr_ok) begin
        res.status = STAT_HDR_ERR;
      end else if (!fr_crc_got || fr_crc != fr_crc_rx) begin
        res.status = STAT_CRC_ERR;
      end else begin
        res.status = STAT_OK;
        res.pos_x = {fr_body[1], fr_body[0]};
        res.pos_y = {fr_body[3], fr_body[2]};
        res.yaw = {fr_body[5], fr_body[4]};
        res.ctrl_flag = fr_body[6];
      end
      pending_poses.push_back(res);
      frame_clear();
    end
  endfunction

  function automatic void append_crc();
    logic [7:0] c;
    c = 8'h00;
    foreach (tx_buf[i]) c = crc8_next(c, tx_buf[i]);
    tx_buf.push_back(c);
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // The sender runs in bursts; a gap only opens between two transactions.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    deframe_byte(b);
    n_bytes++;
  endtask

  task automatic send_buf();
    foreach (tx_buf[i]) send_byte(tx_buf[i]);
    tx_buf.delete();
  endtask

  task automatic build_frame(input int unsigned len);
    tx_buf = '{HdrFirst, HdrSecond, 8'(len)};
    repeat (len) tx_buf.push_back(8'($urandom_range(0, 255)));
    append_crc();
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 12);
    if (r < 98) return $urandom_range(13, 40);
    return $urandom_range(41, 255);
  endfunction

  task automatic test_status_codes();
    tx_buf = '{HdrFirst, HdrSecond, 8'h07, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF};
    append_crc();
    tx_buf.push_back(CharCr);
    tx_buf.push_back(CharLf);
    send_buf();
    // A broken header wins over a missing checksum.
    tx_buf = '{HdrFirst, 8'h00, CharCr, CharLf};
    send_buf();
    tx_buf = '{HdrFirst, HdrSecond, 8'h01, 8'h12};
    append_crc();
    tx_buf[tx_buf.size()-1] = tx_buf[tx_buf.size()-1] ^ 8'h01;
    tx_buf.push_back(CharCr);
    tx_buf.push_back(CharLf);
    send_buf();
  endtask

  task automatic test_short_frames();
    tx_buf = '{HdrFirst, HdrSecond, CharCr, CharLf};
    send_buf();
    // The checksum and terminator land in the payload positions.
    tx_buf = '{HdrFirst, HdrSecond, 8'h00};
    append_crc();
    tx_buf.push_back(CharCr);
    tx_buf.push_back(CharLf);
    send_buf();
    tx_buf = '{HdrFirst, HdrSecond, 8'h04, CharCr, CharLf};
    send_buf();
    tx_buf = '{CharCr, CharLf};
    send_buf();
  endtask

  // The frame runs past the point where the position counter saturates.
  task automatic test_long_frame();
    logic [7:0] b;
    tx_buf = '{HdrFirst, HdrSecond, 8'hFF};
    repeat (255) begin
      b = 8'($urandom_range(0, 255));
      tx_buf.push_back((b == CharCr) ? 8'h0E : b);
    end
    append_crc();
    repeat (260) begin
      b = 8'($urandom_range(0, 255));
      tx_buf.push_back((b == CharCr) ? 8'h0E : b);
    end
    tx_buf.push_back(CharCr);
    tx_buf.push_back(CharLf);
    send_buf();
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (20) begin
      build_frame(0);
      tx_buf.push_back(CharCr);
      tx_buf.push_back(CharLf);
      send_buf();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned r;
    int unsigned k;
    start = n_bytes;
    while (n_bytes - start < RandomBytes) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        build_frame(pick_len());
      end else if (r < 78) begin
        build_frame(pick_len());
        k = $urandom_range(0, tx_buf.size() - 1);
        tx_buf[k] = tx_buf[k] ^ (8'h01 << $urandom_range(0, 7));
      end else if (r < 86) begin
        build_frame(pick_len());
        repeat ($urandom_range(1, tx_buf.size())) void'(tx_buf.pop_back());
      end else if (r < 93) begin
        build_frame(pick_len());
        repeat ($urandom_range(1, 5)) tx_buf.push_back(8'($urandom_range(0, 12)) + 8'h10);
      end else begin
        repeat ($urandom_range(1, 16)) tx_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (r < 93 || $urandom_range(0, 1) == 1) begin
        tx_buf.push_back(CharCr);
        tx_buf.push_back(CharLf);
      end
      send_buf();
    end
  endtask

  // The receiver switches between stall patterns.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        m_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        if (ready_cyc % 64 == 0) ready_mode = $urandom_range(0, 3);
        case (ready_mode)
          0: m_ready <= 1'b1;
          1: m_ready <= (ready_cyc % 4 != 3);
          2: m_ready <= 1'($urandom_range(0, 1));
          default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
        ready_cyc++;
      end
    end
  end

  always @(posedge clk_i) begin
    pose_t want;
    pose_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        got = m_axis_tdata_o[$bits(pose_t)-1:0];
        if (pending_poses.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual %h", $time,
                   m_axis_tdata_o);
        end else begin
          want = pending_poses.pop_front();
          case (want.status)
            STAT_OK: n_ok++;
            STAT_HDR_ERR: n_hdr++;
            default: n_crc++;
          endcase
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("pos_x", want.pos_x, got.pos_x);
          check_field("pos_y", want.pos_y, got.pos_y);
          check_field("yaw", want.yaw, got.yaw);
          check_field("ctrl_flag", 16'(want.ctrl_flag), 16'(got.ctrl_flag));
        end
      end
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    frame_clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_status_codes();
    test_short_frames();
    test_long_frame();
    test_output_stall();
    test_random_traffic();
    s_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes; frames checked: %0d good, %0d bad header, %0d bad or short CRC.",
             n_bytes, n_ok, n_hdr, n_crc);
    $display("Included a frame past index saturation and a %0d-cycle output hold-off.",
             HoldCycles);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[pose_frame_deframer_crc8.f]
rtl/pfd_pkg.sv
rtl/pfd_frame.sv
rtl/pfd_out_reg.sv
rtl/pose_frame_deframer_crc8.sv
test/tb_pose_frame_deframer_crc8.sv
